@@ sv/mips_subset_execute_core_macros.svh @@
// assertion helpers shared by the execute core
`ifndef MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define MSEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MSEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/msec_pkg.sv @@
package msec_pkg;

   typedef logic [31:0] word_type;
   typedef logic [63:0] count_type;
   typedef logic [2:0]  mem_op_type;
   typedef logic [2:0]  fault_type;
   typedef logic [4:0]  reg_idx_type;
   typedef logic [1:0]  ld_kind_type;
   typedef logic [1:0]  src_sel_type;

   localparam word_type BOOT_VECTOR = 32'hBFC0_0000;
   localparam int       ISOLATE_BIT = 16;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // special function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   // coprocessor 0 sub-ops and registers
   localparam reg_idx_type COP_MF       = 5'd0;
   localparam reg_idx_type COP_MT       = 5'd4;
   localparam reg_idx_type CP0_BPC      = 5'd3;
   localparam reg_idx_type CP0_BDA      = 5'd5;
   localparam reg_idx_type CP0_JUMPDEST = 5'd6;
   localparam reg_idx_type CP0_DCIC     = 5'd7;
   localparam reg_idx_type CP0_BDAM     = 5'd9;
   localparam reg_idx_type CP0_BPCM     = 5'd11;
   localparam reg_idx_type CP0_SR       = 5'd12;
   localparam reg_idx_type CP0_CAUSE    = 5'd13;
   localparam reg_idx_type REG_ZERO     = 5'd0;
   localparam reg_idx_type REG_RA       = 5'd31;

   localparam mem_op_type MEM_NONE = 3'd0;
   localparam mem_op_type MEM_LB   = 3'd1;
   localparam mem_op_type MEM_LW   = 3'd2;
   localparam mem_op_type MEM_SB   = 3'd3;
   localparam mem_op_type MEM_SH   = 3'd4;
   localparam mem_op_type MEM_SW   = 3'd5;

   localparam fault_type FAULT_NONE     = 3'd0;
   localparam fault_type FAULT_OVERFLOW = 3'd1;
   localparam fault_type FAULT_OPCODE   = 3'd2;
   localparam fault_type FAULT_COP      = 3'd3;
   localparam fault_type FAULT_HALTED   = 3'd4;

   localparam ld_kind_type LD_NONE = 2'd0;
   localparam ld_kind_type LD_BYTE = 2'd1;
   localparam ld_kind_type LD_WORD = 2'd2;

   // where a registered operand comes from
   localparam src_sel_type SRC_FWD   = 2'd0;
   localparam src_sel_type SRC_DBANK = 2'd1;
   localparam src_sel_type SRC_LBANK = 2'd2;

   // cp0 registers whose writes are accepted and dropped
   function automatic logic cp0_write_ignored(input reg_idx_type idx);
      return (idx == CP0_BPC) || (idx == CP0_BDA) || (idx == CP0_JUMPDEST) ||
             (idx == CP0_DCIC) || (idx == CP0_BDAM) || (idx == CP0_BPCM) ||
             (idx == CP0_CAUSE);
   endfunction

endpackage

@@ sv/mips_subset_execute_core.sv @@
// Integer execute core for a subset of the R3000 instruction set. Each request
// carries the word fetched from the previous response's fetch address and the
// data for the load that response asked for; each request gives exactly one
// response with the new fetch address, the memory operation of the executed
// instruction, the status register and the step count. The instruction
// executed is the one latched by the previous request, which gives the branch
// delay slot; load data lands in the register file one instruction late. A
// request is taken every cycle while the response register is free or being
// emptied, and its response is registered in the next cycle: one instruction
// per cycle, with the single decode/ALU pass between the latched instruction
// and the response register. The register file is two 32-entry banks (one
// written by ALU results, one by returning loads), each with two registered
// read ports, plus a per-register live bank bit and valid bit; operands for
// the next instruction are read while the current one commits, with forwarding
// of that commit's writes. No clearing pass after reset. An overflow, unknown
// opcode or unsupported coprocessor access halts the core until reset; every
// later request then answers with the halted code.
`include "mips_subset_execute_core_macros.svh"

module mips_subset_execute_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  msec_pkg::word_type   req_instruction_word,
   input  msec_pkg::word_type   req_load_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output msec_pkg::word_type   rsp_fetch_address,
   output msec_pkg::mem_op_type rsp_mem_op,
   output msec_pkg::word_type   rsp_mem_address,
   output msec_pkg::word_type   rsp_store_data,
   output msec_pkg::fault_type  rsp_fault,
   output msec_pkg::word_type   rsp_cop_status,
   output msec_pkg::count_type  rsp_step_total
);
   import msec_pkg::*;

   // architectural state
   word_type    pc_ff, pc_in;
   word_type    held_ins_ff;
   word_type    status_ff, status_in;
   count_type   step_count_ff;
   logic        halted_ff;
   ld_kind_type pend_kind_ff, pend_kind_in;
   reg_idx_type pend_tgt_ff, pend_tgt_in;

   // register file: alu bank, load bank, live bank bit and valid bit per register
   word_type    dbank_mem [32];
   word_type    lbank_mem [32];
   logic [31:0] lvt_ff, lvt_in;
   logic [31:0] valid_ff, valid_in;

   // registered operands for the held instruction
   word_type    dbank_s_ff, dbank_t_ff, lbank_s_ff, lbank_t_ff;
   word_type    fwd_s_ff, fwd_s_in, fwd_t_ff, fwd_t_in;
   src_sel_type sel_s_ff, sel_s_in, sel_t_ff, sel_t_in;

   // response register
   logic        rsp_valid_ff;
   word_type    rsp_fa_ff, rsp_fa_in;
   mem_op_type  rsp_mop_ff, rsp_mop_in;
   word_type    rsp_maddr_ff, rsp_maddr_in;
   word_type    rsp_sdata_ff, rsp_sdata_in;
   fault_type   rsp_fault_ff, rsp_fault_in;
   word_type    rsp_status_ff, rsp_status_in;
   count_type   rsp_count_ff, rsp_count_in;

   // decode fields
   logic [5:0]  op, fn;
   reg_idx_type rs, rt, rd, sh;
   logic [15:0] imm;
   word_type    simm, vs, vt;

   // execute results
   word_type    pc_plus4, br_target, ea, sum_st, sum_si;
   logic        ovf_st, ovf_si, isolated;
   logic        d_we;
   reg_idx_type d_dst;
   word_type    d_val;
   mem_op_type  mop;
   word_type    maddr, sdata;
   fault_type   flt;

   // commit
   logic        req_accept, commit, halt_now;
   logic        d_wr, l_wr;
   word_type    l_val;
   count_type   count_next;
   reg_idx_type ra_s, ra_t;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = !rsp_valid_ff || rsp_ready;

   assign op   = held_ins_ff[31:26];
   assign rs   = held_ins_ff[25:21];
   assign rt   = held_ins_ff[20:16];
   assign rd   = held_ins_ff[15:11];
   assign sh   = held_ins_ff[10:6];
   assign fn   = held_ins_ff[5:0];
   assign imm  = held_ins_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};

   // operand select after the registered bank reads
   always_comb begin
      case (sel_s_ff)
         SRC_FWD:   vs = fwd_s_ff;
         SRC_DBANK: vs = dbank_s_ff;
         default:   vs = lbank_s_ff;
      endcase
      case (sel_t_ff)
         SRC_FWD:   vt = fwd_t_ff;
         SRC_DBANK: vt = dbank_t_ff;
         default:   vt = lbank_t_ff;
      endcase
   end

   assign pc_plus4  = pc_ff + 32'd4;
   assign br_target = pc_ff + {simm[29:0], 2'b00};
   assign sum_st    = vs + vt;
   assign sum_si    = vs + simm;
   assign ea        = sum_si;
   assign ovf_st    = (vs[31] == vt[31]) && (sum_st[31] != vs[31]);
   assign ovf_si    = (vs[31] == simm[31]) && (sum_si[31] != vs[31]);
   assign isolated  = status_ff[ISOLATE_BIT];

   // decode and execute of the held instruction
   always_comb begin
      pc_in        = pc_plus4;
      status_in    = status_ff;
      d_we         = 1'b0;
      d_dst        = REG_ZERO;
      d_val        = '0;
      mop          = MEM_NONE;
      maddr        = '0;
      sdata        = '0;
      pend_kind_in = LD_NONE;
      pend_tgt_in  = REG_ZERO;
      flt          = FAULT_NONE;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL: begin
                  d_we = 1'b1; d_dst = rd; d_val = vt << sh;
               end
               FN_JR: pc_in = vs;
               FN_ADD: begin
                  if (ovf_st) begin
                     flt = FAULT_OVERFLOW;
                  end else begin
                     d_we = 1'b1; d_dst = rd; d_val = sum_st;
                  end
               end
               FN_ADDU: begin
                  d_we = 1'b1; d_dst = rd; d_val = sum_st;
               end
               FN_AND: begin
                  d_we = 1'b1; d_dst = rd; d_val = vs & vt;
               end
               FN_OR: begin
                  d_we = 1'b1; d_dst = rd; d_val = vs | vt;
               end
               FN_SLTU: begin
                  d_we = 1'b1; d_dst = rd; d_val = {31'd0, (vs < vt)};
               end
               default: flt = FAULT_OPCODE;
            endcase
         end
         OP_J, OP_JAL: begin
            if (op == OP_JAL) begin
               d_we = 1'b1; d_dst = REG_RA; d_val = pc_plus4;
            end
            pc_in = {pc_plus4[31:28], held_ins_ff[25:0], 2'b00};
         end
         OP_BEQ: if (vs == vt) pc_in = br_target;
         OP_BNE: if (vs != vt) pc_in = br_target;
         OP_ADDI: begin
            if (ovf_si) begin
               flt = FAULT_OVERFLOW;
            end else begin
               d_we = 1'b1; d_dst = rt; d_val = sum_si;
            end
         end
         OP_ADDIU: begin
            d_we = 1'b1; d_dst = rt; d_val = sum_si;
         end
         OP_ANDI: begin
            d_we = 1'b1; d_dst = rt; d_val = vs & {16'd0, imm};
         end
         OP_ORI: begin
            d_we = 1'b1; d_dst = rt; d_val = vs | {16'd0, imm};
         end
         OP_LUI: begin
            d_we = 1'b1; d_dst = rt; d_val = {imm, 16'd0};
         end
         OP_COP0: begin
            if (held_ins_ff[25]) begin
               flt = FAULT_COP;
            end else begin
               case (rs)
                  COP_MF: begin
                     if (rd == CP0_SR) begin
                        d_we = 1'b1; d_dst = rt; d_val = status_ff;
                     end else begin
                        flt = FAULT_COP;
                     end
                  end
                  COP_MT: begin
                     if (rd == CP0_SR) status_in = vt;
                     else if (!cp0_write_ignored(rd)) flt = FAULT_COP;
                  end
                  default: flt = FAULT_COP;
               endcase
            end
         end
         OP_LB, OP_LW: begin
            if (!isolated) begin
               mop          = (op == OP_LB) ? MEM_LB : MEM_LW;
               maddr        = ea;
               pend_kind_in = (op == OP_LB) ? LD_BYTE : LD_WORD;
               pend_tgt_in  = rt;
            end
         end
         OP_SB: begin
            if (!isolated) begin
               mop = MEM_SB; maddr = ea; sdata = {24'd0, vt[7:0]};
            end
         end
         OP_SH: begin
            if (!isolated) begin
               mop = MEM_SH; maddr = ea; sdata = {16'd0, vt[15:0]};
            end
         end
         OP_SW: begin
            if (!isolated) begin
               mop = MEM_SW; maddr = ea; sdata = vt;
            end
         end
         default: flt = FAULT_OPCODE;
      endcase
   end

   assign commit   = req_accept && !halted_ff && (flt == FAULT_NONE);
   assign halt_now = req_accept && !halted_ff && (flt != FAULT_NONE);

   // register writes of this step: returning load, then alu result (alu wins)
   assign l_val = (pend_kind_ff == LD_BYTE) ? {{24{req_load_data[7]}}, req_load_data[7:0]}
                                            : req_load_data;
   assign l_wr  = commit && ((pend_kind_ff == LD_BYTE) || (pend_kind_ff == LD_WORD)) &&
                  (pend_tgt_ff != REG_ZERO);
   assign d_wr  = commit && d_we && (d_dst != REG_ZERO);

   assign count_next = step_count_ff + 64'd1;

   // operand addresses of the instruction that executes next
   assign ra_s = req_instruction_word[25:21];
   assign ra_t = req_instruction_word[20:16];

   // forwarding of this step's writes into next step's operands
   always_comb begin
      fwd_s_in = '0;
      sel_s_in = lvt_ff[ra_s] ? SRC_LBANK : SRC_DBANK;
      if (ra_s == REG_ZERO) begin
         sel_s_in = SRC_FWD;
      end else if (d_wr && (d_dst == ra_s)) begin
         sel_s_in = SRC_FWD; fwd_s_in = d_val;
      end else if (l_wr && (pend_tgt_ff == ra_s)) begin
         sel_s_in = SRC_FWD; fwd_s_in = l_val;
      end else if (!valid_ff[ra_s]) begin
         sel_s_in = SRC_FWD;
      end
      fwd_t_in = '0;
      sel_t_in = lvt_ff[ra_t] ? SRC_LBANK : SRC_DBANK;
      if (ra_t == REG_ZERO) begin
         sel_t_in = SRC_FWD;
      end else if (d_wr && (d_dst == ra_t)) begin
         sel_t_in = SRC_FWD; fwd_t_in = d_val;
      end else if (l_wr && (pend_tgt_ff == ra_t)) begin
         sel_t_in = SRC_FWD; fwd_t_in = l_val;
      end else if (!valid_ff[ra_t]) begin
         sel_t_in = SRC_FWD;
      end
   end

   // live bank and valid bits after this step; alu write lands after the load
   always_comb begin
      valid_in = valid_ff;
      lvt_in   = lvt_ff;
      if (l_wr) begin
         valid_in[pend_tgt_ff] = 1'b1;
         lvt_in[pend_tgt_ff]   = 1'b1;
      end
      if (d_wr) begin
         valid_in[d_dst] = 1'b1;
         lvt_in[d_dst]   = 1'b0;
      end
   end

   // response contents
   always_comb begin
      rsp_fa_in     = pc_ff;
      rsp_mop_in    = MEM_NONE;
      rsp_maddr_in  = '0;
      rsp_sdata_in  = '0;
      rsp_fault_in  = flt;
      rsp_status_in = status_ff;
      rsp_count_in  = step_count_ff;
      if (halted_ff) begin
         rsp_fault_in = FAULT_HALTED;
      end else if (flt == FAULT_NONE) begin
         rsp_fa_in     = pc_in;
         rsp_mop_in    = mop;
         rsp_maddr_in  = maddr;
         rsp_sdata_in  = sdata;
         rsp_status_in = status_in;
         rsp_count_in  = count_next;
      end
   end

   // alu result bank
   always_ff @(posedge clock) begin
      if (d_wr) dbank_mem[d_dst] <= d_val;
      if (commit) begin
         dbank_s_ff <= dbank_mem[ra_s];
         dbank_t_ff <= dbank_mem[ra_t];
      end
   end

   // load result bank
   always_ff @(posedge clock) begin
      if (l_wr) lbank_mem[pend_tgt_ff] <= l_val;
      if (commit) begin
         lbank_s_ff <= lbank_mem[ra_s];
         lbank_t_ff <= lbank_mem[ra_t];
      end
   end

   // architectural state and live bank table
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= BOOT_VECTOR;
         held_ins_ff   <= '0;
         status_ff     <= '0;
         step_count_ff <= '0;
         halted_ff     <= 1'b0;
         pend_kind_ff  <= LD_NONE;
         pend_tgt_ff   <= REG_ZERO;
         valid_ff      <= '0;
         lvt_ff        <= '0;
      end else begin
         if (halt_now) halted_ff <= 1'b1;
         if (commit) begin
            pc_ff         <= pc_in;
            held_ins_ff   <= req_instruction_word;
            status_ff     <= status_in;
            step_count_ff <= count_next;
            pend_kind_ff  <= pend_kind_in;
            pend_tgt_ff   <= pend_tgt_in;
         end
         valid_ff <= valid_in;
         lvt_ff   <= lvt_in;
      end
   end

   // operand source registers; the reset no-op reads zero
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_s_ff <= SRC_FWD;
         sel_t_ff <= SRC_FWD;
         fwd_s_ff <= '0;
         fwd_t_ff <= '0;
      end else if (commit) begin
         sel_s_ff <= sel_s_in;
         sel_t_ff <= sel_t_in;
         fwd_s_ff <= fwd_s_in;
         fwd_t_ff <= fwd_t_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_fa_ff     <= rsp_fa_in;
         rsp_mop_ff    <= rsp_mop_in;
         rsp_maddr_ff  <= rsp_maddr_in;
         rsp_sdata_ff  <= rsp_sdata_in;
         rsp_fault_ff  <= rsp_fault_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fetch_address = rsp_fa_ff;
   assign rsp_mem_op        = rsp_mop_ff;
   assign rsp_mem_address   = rsp_maddr_ff;
   assign rsp_store_data    = rsp_sdata_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_cop_status    = rsp_status_ff;
   assign rsp_step_total    = rsp_count_ff;

   // a halted core stays halted and answers every request with the halted code
   `MSEC_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff, "halt released")
   `MSEC_ASSERT_NEXT(a_halted_rsp, clock, reset, req_accept && halted_ff,
      rsp_fault == FAULT_HALTED, "halted core gave a non-halted response")
   // step count moves by exactly one on a committed request
   `MSEC_ASSERT_NEXT(a_step_count, clock, reset, commit,
      step_count_ff == $past(step_count_ff) + 64'd1, "step count did not advance")
   // a faulting response never carries a memory operation
   `MSEC_ASSERT_SAME(a_fault_no_mem, clock, reset,
      rsp_valid_ff && (rsp_fault_ff != FAULT_NONE),
      (rsp_mop_ff == MEM_NONE) && (rsp_maddr_ff == '0), "memory operation on a fault")

endmodule
